// ===== design/flpe_pkg.sv =====
package flpe_pkg;

  // Port field widths
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned CHUNK_BITS     = 32;
  localparam int unsigned CHUNK_CNT_W    = 6;
  localparam int unsigned CODE_LEN_W     = 7;

  // Default and internal sizes
  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned L_W            = 7;
  localparam int unsigned FIB_MAX        = 10;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QPTR_W         = 2;
  localparam int unsigned QCNT_W         = 3;

  // Action codes
  localparam logic ACT_NATURAL = 1'b0;
  localparam logic ACT_SIGNED  = 1'b1;

  // Fibonacci weights, smallest first
  localparam int unsigned FIB_WEIGHT [FIB_MAX] = '{1, 2, 3, 5, 8, 13, 21, 34, 55, 89};

  typedef struct packed {
    logic               action;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [CHUNK_BITS-1:0]  chunk;
    logic [CHUNK_CNT_W-1:0] chunk_bits;
    logic [CODE_LEN_W-1:0]  code_length;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } pipe_stat_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } queue_stat_t;

  // Number of Fibonacci weights that do not exceed v
  function automatic int unsigned fib_count(input int unsigned v);
    int unsigned n;
    n = 0;
    for (int k = 0; k < FIB_MAX; k++) begin
      if (FIB_WEIGHT[k] <= v) n = n + 1;
    end
    return n;
  endfunction

  // Greedy Zeckendorf digits of l, bit k carries weight FIB_WEIGHT[k]
  function automatic logic [FIB_MAX-1:0] zeck_code(input logic [L_W-1:0] l);
    logic [FIB_MAX-1:0] c;
    int unsigned        rem;
    c   = '0;
    rem = int'(l);
    for (int k = FIB_MAX - 1; k >= 0; k--) begin
      if (rem >= FIB_WEIGHT[k]) begin
        c[k] = 1'b1;
        rem  = rem - FIB_WEIGHT[k];
      end
    end
    return c;
  endfunction

endpackage

// ===== design/fibonacci_length_prefix_encoder.sv =====
// Encodes one value per transaction into a Fibonacci length-prefixed code word
// (Zeckendorf code of the bit width l, smallest weight first, a terminating 1,
// then the value in l bits MSB first) of 3 to 74 bits, delivered as 32-bit
// chunks MSB first with last set on the final one. A transaction is taken when
// start is high and busy is low; it then passes the encoding pipeline, waits in
// the queue and is loaded into the chunker, whose output register drives out_valid.
// The chunker sends one chunk per cycle, and an item takes ceil(code_length/32)
// chunks, 1 to 3; a four-entry queue between the encoding pipeline and the
// chunker absorbs the difference, and busy rises once the items waiting in that
// queue plus those in the two pipeline stages reach four.
// Results cannot be stalled: each chunk is valid for exactly one cycle.
module fibonacci_length_prefix_encoder #(
  parameter int unsigned VALUE_BITS = flpe_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  flpe_pkg::in_item_t  in_data,
  output logic                out_valid,
  output flpe_pkg::out_item_t out_data
);
  import flpe_pkg::*;

  localparam int unsigned CODE_W = fib_count(VALUE_BITS) + 1 + VALUE_BITS;
  localparam int unsigned WORD_W = ((CODE_W + CHUNK_BITS - 1) / CHUNK_BITS) * CHUNK_BITS;
  localparam int unsigned LEN_W  = $clog2(CODE_W + 1);

  pipe_stat_t          pstat;
  queue_stat_t         qstat;
  logic                in_take, pop;
  logic [WORD_W-1:0]   item_word, head_word;
  logic [LEN_W-1:0]    item_len, head_len;
  logic [QCNT_W:0]     occ_c;

  // Hold off new transactions once every queue slot is spoken for
  assign occ_c   = {1'b0, qstat.count} + (QCNT_W + 1)'(pstat.s1_valid)
                 + (QCNT_W + 1)'(pstat.s2_valid);
  assign busy    = (int'(occ_c) >= QUEUE_DEPTH);
  assign in_take = start && !busy;

  flpe_front #(
    .VALUE_BITS (VALUE_BITS),
    .WORD_W     (WORD_W),
    .LEN_W      (LEN_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_item   (in_data),
    .stat      (pstat),
    .item_word (item_word),
    .item_len  (item_len)
  );

  flpe_queue #(
    .WIDTH (WORD_W + LEN_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pstat.s2_valid),
    .push_data ({item_word, item_len}),
    .pop       (pop),
    .head_data ({head_word, head_len}),
    .stat      (qstat)
  );

  flpe_back #(
    .WORD_W (WORD_W),
    .LEN_W  (LEN_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_word (head_word),
    .head_len  (head_len),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Queue never pops empty
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("queue popped while empty");

  // Admission control keeps a slot free for every push
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    pstat.s2_valid |-> (qstat.count < QCNT_W'(QUEUE_DEPTH)))
    else $error("queue pushed while full");

  // Chunks of one code word leave on consecutive cycles
  a_chunks_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |=> out_valid)
    else $error("gap inside a code word");

  // Only the final chunk may be partial
  a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.chunk_bits != '0) &&
                  (out_data.last || (out_data.chunk_bits == CHUNK_CNT_W'(CHUNK_BITS))))
    else $error("partial chunk before the end of a code word");

endmodule

// ===== design/flpe_front.sv =====
module flpe_front #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned WORD_W     = 96,
  parameter int unsigned LEN_W      = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_take,
  input  flpe_pkg::in_item_t  in_item,
  output flpe_pkg::pipe_stat_t stat,
  output logic [WORD_W-1:0]   item_word,
  output logic [LEN_W-1:0]    item_len
);
  import flpe_pkg::*;

  localparam int unsigned FIB_N = fib_count(VALUE_BITS);
  localparam int unsigned SH_W  = $clog2(WORD_W + 1);

  logic                  v1_r, v2_r;
  logic [VALUE_BITS-1:0] z1_r, z2_r;
  logic [L_W-1:0]        l2_r;
  logic [VALUE_BITS-1:0] raw_c, z_c;
  logic [L_W-1:0]        l_c;
  logic [FIB_MAX-1:0]    zk_c;
  logic [LEN_W-1:0]      len_c;
  logic [SH_W-1:0]       shamt_c;
  logic [WORD_W-1:0]     tail_c, word_c;

  // Mask the incoming value and zigzag-map it in signed mode
  always_comb begin
    raw_c = in_item.value[VALUE_BITS-1:0];
    if (in_item.action == ACT_SIGNED) begin
      z_c = raw_c[VALUE_BITS-1] ? {~raw_c[VALUE_BITS-2:0], 1'b1}
                                : {raw_c[VALUE_BITS-2:0], 1'b0};
    end else begin
      z_c = raw_c;
    end
  end

  // Find the bit width, zero counts as one
  always_comb begin
    l_c = L_W'(1);
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (z1_r[i]) l_c = L_W'(i + 1);
    end
  end

  // Assemble the left-aligned code word; the prefix bits above the terminator are zero
  // after the shift, so only set the Zeckendorf ones
  always_comb begin
    zk_c    = zeck_code(l2_r);
    len_c   = LEN_W'(fib_count(int'(l2_r)) + 1 + int'(l2_r));
    shamt_c = SH_W'(WORD_W) - SH_W'(len_c);
    tail_c  = (WORD_W'(1) << l2_r) | WORD_W'(z2_r);
    word_c  = tail_c << shamt_c;
    for (int j = 0; j < FIB_N; j++) begin
      if (zk_c[j]) word_c[WORD_W-1-j] = 1'b1;
    end
  end

  // Advance the two stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_take;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    z1_r <= z_c;
    z2_r <= z1_r;
    l2_r <= l_c;
  end

  assign stat.s1_valid = v1_r;
  assign stat.s2_valid = v2_r;
  assign item_word     = word_c;
  assign item_len      = len_c;

endmodule

// ===== design/flpe_queue.sv =====
module flpe_queue #(
  parameter int unsigned WIDTH = 103
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      head_data,
  output flpe_pkg::queue_stat_t stat
);
  import flpe_pkg::*;

  logic [WIDTH-1:0]  mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign head_data  = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);

endmodule

// ===== design/flpe_back.sv =====
module flpe_back #(
  parameter int unsigned WORD_W = 96,
  parameter int unsigned LEN_W  = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [WORD_W-1:0]     head_word,
  input  logic [LEN_W-1:0]      head_len,
  input  flpe_pkg::queue_stat_t qstat,
  output logic                  pop,
  output logic                  out_valid,
  output flpe_pkg::out_item_t   out_data
);
  import flpe_pkg::*;

  logic              active_r, active_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic              last_c;

  assign last_c = (int'(rem_r) <= CHUNK_BITS);
  assign pop    = !qstat.empty && (!active_r || last_c);

  // Emit one chunk per cycle while a word is active; load the next word on the last chunk or when idle
  always_comb begin
    active_nxt    = active_r;
    word_nxt      = word_r;
    rem_nxt       = rem_r;
    len_nxt       = len_r;
    out_valid_nxt = active_r;
    out_nxt       = out_r;
    if (active_r) begin
      out_nxt.chunk       = word_r[WORD_W-1 -: CHUNK_BITS];
      out_nxt.chunk_bits  = last_c ? CHUNK_CNT_W'(rem_r) : CHUNK_CNT_W'(CHUNK_BITS);
      out_nxt.code_length = CODE_LEN_W'(len_r);
      out_nxt.last        = last_c;
      word_nxt            = word_r << CHUNK_BITS;
      rem_nxt             = rem_r - LEN_W'(CHUNK_BITS);
      if (last_c) active_nxt = 1'b0;
    end
    if (pop) begin
      active_nxt = 1'b1;
      word_nxt   = head_word;
      rem_nxt    = head_len;
      len_nxt    = head_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    rem_r  <= rem_nxt;
    len_r  <= len_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== dv/fibonacci_code_checker.sv =====
`timescale 1ns / 100ps

module fibonacci_code_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  flpe_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  flpe_pkg::out_item_t out_data,
  output int unsigned         mismatches,
  output int unsigned         outstanding
);
  import flpe_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned CODE_MAX    = 160;
  localparam int unsigned FIB_TERMS   = 24;

  out_item_t expected_chunks[$];
  out_item_t want;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Build the code word for one transaction and queue its chunks
  function automatic void encode_chunks(input in_item_t item);
    logic [VALUE_W-1:0]    z;
    logic                  code_bit [CODE_MAX];
    int unsigned           fib [FIB_TERMS];
    int unsigned           width;
    int unsigned           nfib;
    int unsigned           rem;
    int unsigned           len;
    int unsigned           pos;
    int unsigned           cnt;
    logic [CHUNK_BITS-1:0] c;
    out_item_t             r;
    z = item.value;
    // Zigzag: non-negative n to 2n, negative n to -2n-1
    if (item.action == ACT_SIGNED) begin
      z = z[VALUE_W-1] ? {~z[VALUE_W-2:0], 1'b1} : {z[VALUE_W-2:0], 1'b0};
    end
    // Bit width, zero counts as one bit
    width = 1;
    for (int b = 0; b < VALUE_W; b++) begin
      if (z[b]) width = b + 1;
    end
    // Weights 1,2,3,5,... up to the width
    nfib = 0;
    for (int k = 0; k < FIB_TERMS; k++) begin
      fib[k] = (k < 2) ? k + 1 : fib[k-1] + fib[k-2];
      if (fib[k] <= width) nfib = k + 1;
    end
    for (int k = 0; k < CODE_MAX; k++) code_bit[k] = 1'b0;
    // Greedy Zeckendorf digits, largest weight first, stored smallest first
    rem = width;
    for (int k = int'(nfib) - 1; k >= 0; k--) begin
      if (rem >= fib[k]) begin
        code_bit[k] = 1'b1;
        rem = rem - fib[k];
      end
    end
    // Terminator, then the value MSB first
    code_bit[nfib] = 1'b1;
    len = nfib + 1;
    for (int b = int'(width) - 1; b >= 0; b--) begin
      code_bit[len] = z[b];
      len++;
    end
    // Slice into chunks, first code bit at the top
    pos = 0;
    while (pos < len) begin
      cnt = (len - pos > CHUNK_BITS) ? CHUNK_BITS : len - pos;
      c = '0;
      for (int i = 0; i < int'(cnt); i++) c[CHUNK_BITS-1-i] = code_bit[pos+i];
      pos = pos + cnt;
      r.chunk       = c;
      r.chunk_bits  = cnt[CHUNK_CNT_W-1:0];
      r.code_length = len[CODE_LEN_W-1:0];
      r.last        = (pos >= len);
      expected_chunks.push_back(r);
    end
  endfunction

  // Compare each result against the oldest expectation, then record new transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_chunks.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected chunk %h bits %0d len %0d last %0b", $realtime,
                     out_data.chunk, out_data.chunk_bits, out_data.code_length,
                     out_data.last);
        end else begin
          want = expected_chunks.pop_front();
          if (out_data.chunk !== want.chunk || out_data.chunk_bits !== want.chunk_bits ||
              out_data.code_length !== want.code_length || out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: chunk exp %h/%0d/%0d/%0b got %h/%0d/%0d/%0b", $realtime,
                       want.chunk, want.chunk_bits, want.code_length, want.last,
                       out_data.chunk, out_data.chunk_bits, out_data.code_length,
                       out_data.last);
          end
        end
      end
      if (start && !busy) encode_chunks(in_data);
    end
    outstanding = expected_chunks.size();
  end

endmodule

// ===== dv/fibonacci_length_prefix_encoder_tb.sv =====
`timescale 1ns / 100ps

module fibonacci_length_prefix_encoder_tb;
  import flpe_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS  = 28;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycles = 0;
  int unsigned sender_gap;
  int unsigned boundary_widths [5] = '{23, 24, 25, 54, 55};
  int unsigned phase_gap [3] = '{14, 59, 0};

  fibonacci_length_prefix_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  fibonacci_code_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Random value whose top set bit is bit w-1
  function automatic logic [VALUE_W-1:0] value_of_width(input int unsigned w);
    logic [VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    if (w < VALUE_W) v = v & ((64'd1 << w) - 64'd1);
    v[w-1] = 1'b1;
    return v;
  endfunction

  // Idle at random, then hold the transaction until it is taken
  task automatic send_item(input logic act, input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < sender_gap) begin
      @(negedge clk);
      start   <= 1'b0;
      in_data <= {1'($urandom), $urandom, $urandom};
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= in_item_t'{action: act, value: v};
    do @(posedge clk); while (busy);
  endtask

  initial begin
    logic               act;
    logic [VALUE_W-1:0] v;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    sender_gap = phase_gap[0];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Field extremes and both modes around zero and the ends of the range
    send_item(ACT_NATURAL, 64'd0);
    send_item(ACT_NATURAL, 64'd1);
    send_item(ACT_NATURAL, 64'd2);
    send_item(ACT_NATURAL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_NATURAL, 64'h8000_0000_0000_0000);
    send_item(ACT_NATURAL, 64'h0000_0000_FFFF_FFFF);
    send_item(ACT_SIGNED, 64'd0);
    send_item(ACT_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_SIGNED, 64'd1);
    send_item(ACT_SIGNED, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(ACT_SIGNED, 64'h8000_0000_0000_0000);
    send_item(ACT_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
    // Widths whose code lengths straddle chunk boundaries
    foreach (boundary_widths[i]) send_item(ACT_NATURAL, value_of_width(boundary_widths[i]));

    // Random values, mostly of random width, over three idle settings
    for (int p = 0; p < 3; p++) begin
      sender_gap = phase_gap[p];
      repeat (PHASE_ITEMS) begin
        act = 1'($urandom_range(1));
        if ($urandom_range(3) == 0) v = {$urandom, $urandom};
        else v = value_of_width($urandom_range(1, VALUE_W));
        if (act == ACT_SIGNED && $urandom_range(1) == 1) v = ~v;
        send_item(act, v);
      end
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain and give the verdict
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
